FILE: src/lcau_pkg.sv
package lcau_pkg;

    localparam int MAX_CLUSTERS = 64;
    localparam int COUNT_BITS   = 16;

    localparam int IDX_W      = $clog2(MAX_CLUSTERS);
    localparam int USED_W     = $clog2(MAX_CLUSTERS + 1);
    localparam int CRD_W      = 16;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 34;
    localparam int RAD_W      = 16;
    localparam int RAD2_W     = 2 * RAD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEP_W = $clog2(SUM_W);

    // item kinds
    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_PASS  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // point outcomes
    localparam logic [1:0] OUT_AVERAGED = 2'd0;
    localparam logic [1:0] OUT_COUNTED  = 2'd1;
    localparam logic [1:0] OUT_NEW      = 2'd2;
    localparam logic [1:0] OUT_FULL     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 2'd3;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_UPDATE,
        ST_PASS_ENTRY,
        ST_PASS_DIV,
        ST_PASS_MOVE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        ACT_AVERAGE,
        ACT_COUNT,
        ACT_OPEN
    } t_action;

    typedef struct packed {
        logic signed [CRD_W-1:0]  cx;
        logic signed [CRD_W-1:0]  cy;
        logic signed [CRD_W-1:0]  cz;
        logic signed [SUM_W-1:0]  sx;
        logic signed [SUM_W-1:0]  sy;
        logic signed [SUM_W-1:0]  sz;
        logic [COUNT_BITS-1:0]    mcnt;
        logic [COUNT_BITS-1:0]    acnt;
    } t_entry;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         tag;
        logic signed [CRD_W-1:0]  ax;
        logic signed [CRD_W-1:0]  ay;
        logic signed [CRD_W-1:0]  az;
        logic signed [CRD_W-1:0]  bx;
        logic signed [CRD_W-1:0]  by;
        logic signed [CRD_W-1:0]  bz;
    } t_dist_req;

    typedef struct packed {
        logic                     valid;
        logic                     busy;
        logic [IDX_W-1:0]         tag;
        logic [DIST_W-1:0]        dsq;
    } t_dist_rsp;

endpackage

FILE: src/lcau_cell.sv
module lcau_cell import lcau_pkg::*; (
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    // one ring stage, takes its neighbor's entry on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: src/lcau_dist.sv
module lcau_dist import lcau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dist_req i_req,
    output t_dist_rsp o_rsp
);

    logic signed [CRD_W:0]  w_dx, w_dy, w_dz;
    logic signed [DIST_W-1:0] w_px, w_py, w_pz;

    logic              r_s1_valid;
    logic [IDX_W-1:0]  r_s1_tag;
    logic [SQ_W-1:0]   r_sqx, r_sqy, r_sqz;
    logic              r_s2_valid;
    logic [IDX_W-1:0]  r_s2_tag;
    logic [DIST_W-1:0] r_dist;

    always_comb begin
        w_dx = {i_req.ax[CRD_W-1], i_req.ax} - {i_req.bx[CRD_W-1], i_req.bx};
        w_dy = {i_req.ay[CRD_W-1], i_req.ay} - {i_req.by[CRD_W-1], i_req.by};
        w_dz = {i_req.az[CRD_W-1], i_req.az} - {i_req.bz[CRD_W-1], i_req.bz};
        w_px = w_dx * w_dx;
        w_py = w_dy * w_dy;
        w_pz = w_dz * w_dz;
    end

    // stage 1: squares, stage 2: sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_tag <= i_req.tag;
        r_sqx    <= w_px[SQ_W-1:0];
        r_sqy    <= w_py[SQ_W-1:0];
        r_sqz    <= w_pz[SQ_W-1:0];
        r_s2_tag <= r_s1_tag;
        r_dist   <= DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);
    end

    assign o_rsp.valid = r_s2_valid;
    assign o_rsp.busy  = r_s1_valid | r_s2_valid;
    assign o_rsp.tag   = r_s2_tag;
    assign o_rsp.dsq   = r_dist;

endmodule

FILE: src/lcau_div.sv
module lcau_div import lcau_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [COUNT_BITS-1:0]   i_count,
    output logic                    o_done,
    output logic signed [CRD_W-1:0] o_quot
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]        r_num;
    logic [COUNT_BITS-1:0]   r_rem;
    logic [COUNT_BITS-1:0]   r_den;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_q;

    logic [SUM_W:0]          w_ext;
    logic [SUM_W:0]          w_mag;
    logic [COUNT_BITS:0]     w_trial;
    logic                    w_ge;
    logic [COUNT_BITS:0]     w_rem;

    always_comb begin
        w_ext   = {i_sum[SUM_W-1], i_sum};
        w_mag   = i_sum[SUM_W-1] ? -w_ext : w_ext;
        w_trial = {r_rem, r_num[SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_rem   = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
    end

    // restoring division on magnitudes, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= w_mag[SUM_W-1:0];
                r_rem  <= '0;
                r_den  <= i_count;
                r_neg  <= i_sum[SUM_W-1];
                r_q    <= '0;
            end else if (r_busy) begin
                r_num  <= {r_num[SUM_W-2:0], 1'b0};
                r_rem  <= w_rem[COUNT_BITS-1:0];
                r_q    <= {r_q[SUM_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -r_q[CRD_W-1:0] : r_q[CRD_W-1:0];

endmodule

FILE: src/leader_cluster_assign_update_unit.sv
// Leader clustering of 3D points with centroid update. Up to MAX_CLUSTERS centers
// (signed Q8.8) live in a ring of cells that rotates one place a cycle past a
// shared distance pipeline and three serial dividers, pausing while the pipe
// drains, a point is decided or the dividers work; one item is worked at a
// time and stall stays high until its result word is loaded. A point takes one
// full rotation to find the nearest center (none on an empty table), one to write
// the chosen entry back, since the ring has to come back into line. An end-of-pass
// item takes one rotation that halts at each held center that has averaged points
// while the 32-step dividers run. Clear and unused kinds go straight to the result
// word. The result word waits in an output register, so the next item can be taken while it is held.
module leader_cluster_assign_update_unit import lcau_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic signed [CRD_W-1:0]  i_coord_x,
    input  logic signed [CRD_W-1:0]  i_coord_y,
    input  logic signed [CRD_W-1:0]  i_coord_z,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [USED_W-1:0]        o_cluster_number,
    output logic [1:0]               o_outcome,
    output logic [DIST_W-1:0]        o_distance_squared,
    output logic                     o_converged,
    output logic [USED_W-1:0]        o_center_total,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [RAD_W-1:0]         i_cfg_data
);

    // control state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;      // logical index of the entry at the head
    logic [USED_W-1:0]  r_used, n_used;
    logic               r_out_valid, n_out_valid;

    // configuration and its squares
    logic [RAD_W-1:0]   r_cut, n_cut, r_exc, n_exc, r_drift, n_drift, r_tol, n_tol;
    logic [RAD2_W-1:0]  r_cut2, r_exc2, r_drift2, r_tol2;

    // item context
    logic signed [CRD_W-1:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic               r_have, n_have;
    logic [DIST_W-1:0]  r_bd, n_bd;
    logic [IDX_W-1:0]   r_best, n_best;
    t_action            r_act, n_act;
    logic [IDX_W-1:0]   r_target, n_target;
    logic [USED_W-1:0]  r_num, n_num;
    logic [1:0]         r_outc, n_outc;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic               r_conv, n_conv;

    // result word
    logic [USED_W-1:0]  r_o_num, n_o_num, r_o_total, n_o_total;
    logic [1:0]         r_o_outc, n_o_outc;
    logic [DIST_W-1:0]  r_o_dist, n_o_dist;
    logic               r_o_conv, n_o_conv;

    // ring and shared units
    t_entry             w_cell_q [MAX_CLUSTERS];
    t_entry             w_head, w_tail, w_upd, w_clr;
    logic               w_shift;
    logic               w_last;
    logic               w_live;
    logic [IDX_W-1:0]   w_idx_next;
    t_dist_req          w_req;
    t_dist_rsp          w_rsp;
    logic               w_div_start;
    logic [2:0]         w_div_done;
    logic signed [CRD_W-1:0] w_avg_x, w_avg_y, w_avg_z;
    logic               w_closer;

    function automatic logic signed [SUM_W-1:0] f_sat_add(
        input logic signed [SUM_W-1:0] s,
        input logic signed [CRD_W-1:0] p
    );
        logic signed [SUM_W:0] t;
        t = {s[SUM_W-1], s} + {{(SUM_W + 1 - CRD_W){p[CRD_W-1]}}, p};
        if (t[SUM_W] != t[SUM_W-1]) begin
            f_sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            f_sat_add = t[SUM_W-1:0];
        end
    endfunction

    // ring of entry cells, head at cell 0, the tail takes the (possibly updated) head
    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_ring
        if (g == MAX_CLUSTERS - 1) begin : g_tail
            lcau_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_tail),
                .o_entry (w_cell_q[g])
            );
        end else begin : g_mid
            lcau_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_cell_q[g+1]),
                .o_entry (w_cell_q[g])
            );
        end
    end

    assign w_head = w_cell_q[0];

    lcau_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // one divider per axis, all started together
    lcau_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_head.sx),
        .i_count (w_head.acnt),
        .o_done  (w_div_done[0]),
        .o_quot  (w_avg_x)
    );

    lcau_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_head.sy),
        .i_count (w_head.acnt),
        .o_done  (w_div_done[1]),
        .o_quot  (w_avg_y)
    );

    lcau_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_head.sz),
        .i_count (w_head.acnt),
        .o_done  (w_div_done[2]),
        .o_quot  (w_avg_z)
    );

    // entry as rewritten by the chosen point action
    always_comb begin
        w_upd = w_head;
        unique case (r_act)
            ACT_OPEN: begin
                w_upd.cx   = r_px;
                w_upd.cy   = r_py;
                w_upd.cz   = r_pz;
                w_upd.sx   = SUM_W'(r_px);
                w_upd.sy   = SUM_W'(r_py);
                w_upd.sz   = SUM_W'(r_pz);
                w_upd.mcnt = COUNT_BITS'(1);
                w_upd.acnt = COUNT_BITS'(1);
            end
            ACT_AVERAGE: begin
                if (w_head.mcnt != CNT_MAX) begin
                    w_upd.mcnt = w_head.mcnt + 1'b1;
                end
                // a saturated averaged count still reports averaged, sums stay
                if (w_head.acnt != CNT_MAX) begin
                    w_upd.acnt = w_head.acnt + 1'b1;
                    w_upd.sx   = f_sat_add(w_head.sx, r_px);
                    w_upd.sy   = f_sat_add(w_head.sy, r_py);
                    w_upd.sz   = f_sat_add(w_head.sz, r_pz);
                end
            end
            ACT_COUNT: begin
                if (w_head.mcnt != CNT_MAX) begin
                    w_upd.mcnt = w_head.mcnt + 1'b1;
                end
            end
            default: begin
                w_upd = w_head;
            end
        endcase

        // end of pass leaves every held entry with empty sums and counts
        w_clr      = w_head;
        w_clr.sx   = '0;
        w_clr.sy   = '0;
        w_clr.sz   = '0;
        w_clr.mcnt = '0;
        w_clr.acnt = '0;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_px        = r_px;
        n_py        = r_py;
        n_pz        = r_pz;
        n_have      = r_have;
        n_bd        = r_bd;
        n_best      = r_best;
        n_act       = r_act;
        n_target    = r_target;
        n_num       = r_num;
        n_outc      = r_outc;
        n_dist      = r_dist;
        n_conv      = r_conv;
        n_out_valid = r_out_valid & i_out_stall;
        n_o_num     = r_o_num;
        n_o_outc    = r_o_outc;
        n_o_dist    = r_o_dist;
        n_o_conv    = r_o_conv;
        n_o_total   = r_o_total;
        n_cut       = r_cut;
        n_exc       = r_exc;
        n_drift     = r_drift;
        n_tol       = r_tol;

        w_shift     = 1'b0;
        w_tail      = w_head;
        w_req       = '0;
        w_div_start = 1'b0;

        w_last     = (r_idx == IDX_W'(MAX_CLUSTERS - 1));
        w_idx_next = w_last ? '0 : r_idx + 1'b1;
        w_live     = (USED_W'(r_idx) < r_used);
        w_closer   = w_rsp.valid && (!r_have || (w_rsp.dsq < r_bd));

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CUTOFF:  n_cut   = i_cfg_data;
                CFG_EXCLUDE: n_exc   = i_cfg_data;
                CFG_DRIFT:   n_drift = i_cfg_data;
                CFG_TOL:     n_tol   = i_cfg_data;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_px   = i_coord_x;
                    n_py   = i_coord_y;
                    n_pz   = i_coord_z;
                    n_num  = '0;
                    n_outc = OUT_AVERAGED;
                    n_dist = '0;
                    n_conv = 1'b0;
                    n_have = 1'b0;
                    unique case (i_kind)
                        KIND_POINT: begin
                            if (r_used == '0) begin
                                // empty table: the point opens the first center
                                n_act    = ACT_OPEN;
                                n_target = '0;
                                n_num    = USED_W'(1);
                                n_outc   = OUT_NEW;
                                n_used   = USED_W'(1);
                                n_state  = ST_UPDATE;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        KIND_PASS: begin
                            n_conv  = 1'b1;
                            n_state = ST_PASS_ENTRY;
                        end
                        KIND_CLEAR: begin
                            n_used  = '0;
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // every held center goes through the distance pipe once
                w_req.valid = w_live;
                w_req.tag   = r_idx;
                w_req.ax    = w_head.cx;
                w_req.ay    = w_head.cy;
                w_req.az    = w_head.cz;
                w_req.bx    = r_px;
                w_req.by    = r_py;
                w_req.bz    = r_pz;
                w_shift     = 1'b1;
                n_idx       = w_idx_next;
                if (w_closer) begin
                    n_have = 1'b1;
                    n_bd   = w_rsp.dsq;
                    n_best = w_rsp.tag;
                end
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end

            ST_DRAIN: begin
                if (w_closer) begin
                    n_have = 1'b1;
                    n_bd   = w_rsp.dsq;
                    n_best = w_rsp.tag;
                end
                if (!w_rsp.busy) begin
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                n_target = r_best;
                n_num    = USED_W'(r_best) + 1'b1;
                n_dist   = r_bd;
                n_state  = ST_UPDATE;
                if (r_bd <= DIST_W'(r_cut2)) begin
                    n_act  = ACT_AVERAGE;
                    n_outc = OUT_AVERAGED;
                end else if (r_bd <= DIST_W'(r_exc2)) begin
                    n_act  = ACT_COUNT;
                    n_outc = OUT_COUNTED;
                end else if (r_used >= USED_W'(MAX_CLUSTERS)) begin
                    // no room left: counted into the nearest center
                    n_act  = ACT_COUNT;
                    n_outc = OUT_FULL;
                end else begin
                    n_act    = ACT_OPEN;
                    n_target = IDX_W'(r_used);
                    n_num    = r_used + 1'b1;
                    n_outc   = OUT_NEW;
                    n_dist   = '0;
                    n_used   = r_used + 1'b1;
                end
            end

            ST_UPDATE: begin
                w_shift = 1'b1;
                n_idx   = w_idx_next;
                if (r_idx == r_target) begin
                    w_tail = w_upd;
                end
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end

            ST_PASS_ENTRY: begin
                if (w_live && (w_head.acnt != '0)) begin
                    w_div_start = 1'b1;
                    n_state     = ST_PASS_DIV;
                end else begin
                    // no averaged points or not held: center stays put
                    w_shift = 1'b1;
                    n_idx   = w_idx_next;
                    if (w_live) begin
                        w_tail = w_clr;
                    end
                    if (w_last) begin
                        n_state = ST_DONE;
                    end
                end
            end

            ST_PASS_DIV: begin
                if (w_div_done[0]) begin
                    w_req.valid = 1'b1;
                    w_req.tag   = r_idx;
                    w_req.ax    = w_head.cx;
                    w_req.ay    = w_head.cy;
                    w_req.az    = w_head.cz;
                    w_req.bx    = w_avg_x;
                    w_req.by    = w_avg_y;
                    w_req.bz    = w_avg_z;
                    n_state     = ST_PASS_MOVE;
                end
            end

            ST_PASS_MOVE: begin
                if (w_rsp.valid) begin
                    w_shift = 1'b1;
                    n_idx   = w_idx_next;
                    w_tail  = w_clr;
                    // move only when above tolerance and within drift, the drift bound inclusive
                    if ((w_rsp.dsq <= DIST_W'(r_drift2)) && (w_rsp.dsq > DIST_W'(r_tol2))) begin
                        w_tail.cx = w_avg_x;
                        w_tail.cy = w_avg_y;
                        w_tail.cz = w_avg_z;
                        n_conv    = 1'b0;
                    end
                    n_state = w_last ? ST_DONE : ST_PASS_ENTRY;
                end
            end

            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_num     = r_num;
                    n_o_outc    = r_outc;
                    n_o_dist    = r_dist;
                    n_o_conv    = r_conv;
                    n_o_total   = r_used;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_cut       <= RAD_W'(512);
            r_exc       <= RAD_W'(1536);
            r_drift     <= RAD_W'(6400);
            r_tol       <= RAD_W'(1);
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_cut       <= n_cut;
            r_exc       <= n_exc;
            r_drift     <= n_drift;
            r_tol       <= n_tol;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_px      <= n_px;
        r_py      <= n_py;
        r_pz      <= n_pz;
        r_have    <= n_have;
        r_bd      <= n_bd;
        r_best    <= n_best;
        r_act     <= n_act;
        r_target  <= n_target;
        r_num     <= n_num;
        r_outc    <= n_outc;
        r_dist    <= n_dist;
        r_conv    <= n_conv;
        r_o_num   <= n_o_num;
        r_o_outc  <= n_o_outc;
        r_o_dist  <= n_o_dist;
        r_o_conv  <= n_o_conv;
        r_o_total <= n_o_total;
        // radii compared as squares, refreshed every cycle
        r_cut2    <= {{RAD_W{1'b0}}, r_cut} * {{RAD_W{1'b0}}, r_cut};
        r_exc2    <= {{RAD_W{1'b0}}, r_exc} * {{RAD_W{1'b0}}, r_exc};
        r_drift2  <= {{RAD_W{1'b0}}, r_drift} * {{RAD_W{1'b0}}, r_drift};
        r_tol2    <= {{RAD_W{1'b0}}, r_tol} * {{RAD_W{1'b0}}, r_tol};
    end

    assign o_in_stall         = (r_state != ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_cluster_number   = r_o_num;
    assign o_outcome          = r_o_outc;
    assign o_distance_squared = r_o_dist;
    assign o_converged        = r_o_conv;
    assign o_center_total     = r_o_total;
    assign o_cfg_ready        = 1'b1;

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(MAX_CLUSTERS))
        else $error("center count beyond table size");

    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_idx == '0))
        else $error("ring not back in line when idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != ST_IDLE))
        else $error("accepted word not taken into work");

    a_rsp_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (r_state == ST_SCAN || r_state == ST_DRAIN
                         || r_state == ST_PASS_MOVE))
        else $error("distance result outside a scan or move check");

    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_done[0] == w_div_done[1]) && (w_div_done[0] == w_div_done[2]))
        else $error("axis dividers out of step");

endmodule

FILE: bench/leader_cluster_assign_update_unit_test.sv
module leader_cluster_assign_update_unit_test;
    import lcau_pkg::*;

    // one input word and one result word
    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_word_t;

    typedef struct {
        logic [USED_W-1:0] number;
        logic [1:0]        outcome;
        logic [DIST_W-1:0] dsq;
        logic              conv;
        logic [USED_W-1:0] total;
    } result_word_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int QUIET_TAIL     = 150;
    localparam int TOTAL_WORDS    = 1820;

    logic i_clk;
    logic i_rst_n;

    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              in_kind;
    logic signed [CRD_W-1:0] in_x;
    logic signed [CRD_W-1:0] in_y;
    logic signed [CRD_W-1:0] in_z;

    logic                    out_valid;
    logic                    out_stall;
    logic [USED_W-1:0]       out_number;
    logic [1:0]              out_outcome;
    logic [DIST_W-1:0]       out_dist;
    logic                    out_conv;
    logic [USED_W-1:0]       out_total;

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [RAD_W-1:0]        cfg_data;

    leader_cluster_assign_update_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_kind             (in_kind),
        .i_coord_x          (in_x),
        .i_coord_y          (in_y),
        .i_coord_z          (in_z),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_cluster_number   (out_number),
        .o_outcome          (out_outcome),
        .o_distance_squared (out_dist),
        .o_converged        (out_conv),
        .o_center_total     (out_total),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // shadow copy of the cluster table
    longint ctr_pos [MAX_CLUSTERS][3];
    longint ctr_sum [MAX_CLUSTERS][3];
    longint ctr_members [MAX_CLUSTERS];
    longint ctr_averaged [MAX_CLUSTERS];
    int     ctr_used;

    // shadow copy of the radius registers
    longint cutoff_r;
    longint exclude_r;
    longint drift_r;
    longint tol_r;

    point_word_t  pending_words [$];
    result_word_t expected_results [$];

    int  mismatches;
    int  words_total;
    int  words_taken;
    int  results_seen;
    int  idle_cycles;
    bit  quiet;

    point_word_t cur_word;
    int in_gap;
    int out_gap;

    // squared distance between a stored center and a point
    function automatic longint dist_sq(longint ax, longint ay, longint az,
                                       longint bx, longint by, longint bz);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
    endfunction

    // seed a new center from a point
    function automatic void open_center(int idx, longint p [3]);
        for (int k = 0; k < 3; k++) begin
            ctr_pos[idx][k] = p[k];
            ctr_sum[idx][k] = p[k];
        end
        ctr_members[idx]  = 1;
        ctr_averaged[idx] = 1;
    endfunction

    // work out the result word of one item and advance the shadow table
    function automatic result_word_t cluster_step(point_word_t w);
        result_word_t r;
        longint p [3];
        longint best_d;
        longint d;
        longint avg [3];
        longint cnt_max;
        int     best;
        r.number  = '0;
        r.outcome = OUT_AVERAGED;
        r.dsq     = '0;
        r.conv    = 1'b0;
        cnt_max   = (longint'(1) << COUNT_BITS) - 1;
        p[0] = w.x;
        p[1] = w.y;
        p[2] = w.z;
        if (w.kind == KIND_POINT) begin
            if (ctr_used == 0) begin
                open_center(0, p);
                ctr_used  = 1;
                r.number  = USED_W'(1);
                r.outcome = OUT_NEW;
            end else begin
                best   = 0;
                best_d = dist_sq(ctr_pos[0][0], ctr_pos[0][1], ctr_pos[0][2],
                                 p[0], p[1], p[2]);
                for (int i = 1; i < ctr_used; i++) begin
                    d = dist_sq(ctr_pos[i][0], ctr_pos[i][1], ctr_pos[i][2],
                                p[0], p[1], p[2]);
                    // strict compare keeps ties on the lowest index
                    if (d < best_d) begin
                        best_d = d;
                        best   = i;
                    end
                end
                if (best_d <= cutoff_r * cutoff_r) begin
                    if (ctr_members[best] < cnt_max) ctr_members[best]++;
                    if (ctr_averaged[best] < cnt_max) begin
                        ctr_averaged[best]++;
                        for (int k = 0; k < 3; k++) begin
                            ctr_sum[best][k] += p[k];
                            if (ctr_sum[best][k] > 64'sd2147483647)
                                ctr_sum[best][k] = 64'sd2147483647;
                            if (ctr_sum[best][k] < -64'sd2147483648)
                                ctr_sum[best][k] = -64'sd2147483648;
                        end
                    end
                    r.number  = USED_W'(best + 1);
                    r.outcome = OUT_AVERAGED;
                    r.dsq     = DIST_W'(best_d);
                end else if (best_d <= exclude_r * exclude_r || ctr_used >= MAX_CLUSTERS) begin
                    if (ctr_members[best] < cnt_max) ctr_members[best]++;
                    r.number  = USED_W'(best + 1);
                    r.outcome = (best_d <= exclude_r * exclude_r) ? OUT_COUNTED : OUT_FULL;
                    r.dsq     = DIST_W'(best_d);
                end else begin
                    open_center(ctr_used, p);
                    ctr_used++;
                    r.number  = USED_W'(ctr_used);
                    r.outcome = OUT_NEW;
                end
            end
        end else if (w.kind == KIND_PASS) begin
            r.conv = 1'b1;
            for (int i = 0; i < ctr_used; i++) begin
                if (ctr_averaged[i] > 0) begin
                    // signed divide truncates toward zero
                    for (int k = 0; k < 3; k++) avg[k] = ctr_sum[i][k] / ctr_averaged[i];
                    d = dist_sq(ctr_pos[i][0], ctr_pos[i][1], ctr_pos[i][2],
                                avg[0], avg[1], avg[2]);
                    if (d <= drift_r * drift_r && d > tol_r * tol_r) begin
                        r.conv = 1'b0;
                        for (int k = 0; k < 3; k++) ctr_pos[i][k] = avg[k];
                    end
                end
                for (int k = 0; k < 3; k++) ctr_sum[i][k] = 0;
                ctr_members[i]  = 0;
                ctr_averaged[i] = 0;
            end
        end else if (w.kind == KIND_CLEAR) begin
            ctr_used = 0;
        end
        r.total = USED_W'(ctr_used);
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // driver: feeds the input channel from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   = 0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.insert(expected_results.size(), cluster_step(cur_word));
                words_taken++;
            end
            // a stalled word holds still
            if (!(in_valid && in_stall)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0 && !quiet
                             && $urandom_range(0, 15) == 0) begin
                    in_gap   = $urandom_range(1, 12) - 1;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    in_kind  <= cur_word.kind;
                    in_x     <= cur_word.x;
                    in_y     <= cur_word.y;
                    in_z     <= cur_word.z;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stall on the result channel and field compare
    always @(posedge i_clk) begin
        result_word_t e;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            out_gap   = 0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word, cluster_number %0d", out_number);
                    mismatches++;
                end else begin
                    e = expected_results.pop_front();
                    if (out_number !== e.number) begin
                        $error("cluster_number expected %0d actual %0d", e.number, out_number);
                        mismatches++;
                    end
                    if (out_outcome !== e.outcome) begin
                        $error("outcome expected %0d actual %0d", e.outcome, out_outcome);
                        mismatches++;
                    end
                    if (out_dist !== e.dsq) begin
                        $error("distance_squared expected %0d actual %0d", e.dsq, out_dist);
                        mismatches++;
                    end
                    if (out_conv !== e.conv) begin
                        $error("converged expected %0d actual %0d", e.conv, out_conv);
                        mismatches++;
                    end
                    if (out_total !== e.total) begin
                        $error("center_total expected %0d actual %0d", e.total, out_total);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                out_gap   = $urandom_range(1, 12) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // the last stretch of the run goes without idling
    always @(posedge i_clk) begin
        if (words_total >= TOTAL_WORDS && words_taken >= words_total - QUIET_TAIL)
            quiet <= 1'b1;
    end

    task automatic write_radius(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CUTOFF:  cutoff_r  = val;
            CFG_EXCLUDE: exclude_r = val;
            CFG_DRIFT:   drift_r   = val;
            default:     tol_r     = val;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic add_word(logic [1:0] k, int x, int y, int z);
        point_word_t w;
        w.kind = k;
        w.x    = CRD_W'(x);
        w.y    = CRD_W'(y);
        w.z    = CRD_W'(z);
        pending_words.insert(pending_words.size(), w);
        words_total++;
    endtask

    // wait until every word is taken and every result checked
    task automatic drain();
        @(posedge i_clk);
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // random items: mostly points near a few seeds, plus full-range noise
    task automatic add_random(int n, int spread);
        int seeds [6][3];
        int r;
        int s;
        for (int i = 0; i < 6; i++)
            for (int k = 0; k < 3; k++) seeds[i][k] = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                add_word(KIND_CLEAR, $urandom, $urandom, $urandom);
            end else if (r < 6) begin
                add_word(KIND_PASS, $urandom, $urandom, $urandom);
            end else if (r < 7) begin
                add_word(2'd3, $urandom, $urandom, $urandom);
            end else if (r < 25) begin
                add_word(KIND_POINT, $urandom, $urandom, $urandom);
            end else begin
                s = $urandom_range(0, 5);
                add_word(KIND_POINT,
                         seeds[s][0] + $urandom_range(0, 2 * spread) - spread,
                         seeds[s][1] + $urandom_range(0, 2 * spread) - spread,
                         seeds[s][2] + $urandom_range(0, 2 * spread) - spread);
            end
        end
    endtask

    initial begin
        in_valid  = 1'b0;
        in_kind   = KIND_POINT;
        in_x      = '0;
        in_y      = '0;
        in_z      = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CUTOFF;
        cfg_data  = '0;
        idle_cycles = 0;
        quiet       = 1'b0;
        mismatches  = 0;
        words_total = 0;
        words_taken = 0;
        results_seen = 0;
        ctr_used    = 0;
        cutoff_r    = 512;
        exclude_r   = 1536;
        drift_r     = 6400;
        tol_r       = 1;
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
            ctr_members[i]  = 0;
            ctr_averaged[i] = 0;
            for (int k = 0; k < 3; k++) begin
                ctr_pos[i][k] = 0;
                ctr_sum[i][k] = 0;
            end
        end

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset radii, boundaries, ties, extremes, every kind
        add_word(KIND_POINT, 0, 0, 0);          // empty table opens center 1
        add_word(KIND_POINT, 0, 0, 0);          // zero distance
        add_word(KIND_POINT, 0, 0, 512);        // exactly on cutoff
        add_word(KIND_POINT, 0, 0, 513);        // counted only
        add_word(KIND_POINT, 0, 0, 1536);       // exactly on exclude
        add_word(KIND_POINT, 0, 0, 1537);       // opens a center
        add_word(KIND_POINT, 32767, 32767, 32767);
        add_word(KIND_POINT, -32768, -32768, -32768);
        add_word(KIND_POINT, -32768, 32767, -32768);
        add_word(KIND_POINT, 32767, 32767, 32700);
        add_word(KIND_PASS, 0, 0, 0);           // centers move
        add_word(KIND_PASS, 0, 0, 0);           // nothing averaged, converged
        add_word(2'd3, -1, -1, -1);             // unused kind
        add_word(KIND_CLEAR, 0, 0, 0);
        add_word(KIND_POINT, 0, 0, -1000);
        add_word(KIND_POINT, 0, 0, 1000);
        add_word(KIND_POINT, 0, 0, 0);          // tie goes to lowest index
        add_word(KIND_POINT, -1, 1, -1);
        add_word(KIND_PASS, 0, 0, 0);
        add_word(KIND_CLEAR, 0, 0, 0);
        drain();

        // no averaging, every distinct point opens a center until full
        write_radius(CFG_CUTOFF, 16'd0);
        write_radius(CFG_EXCLUDE, 16'd0);
        write_radius(CFG_DRIFT, 16'hFFFF);
        write_radius(CFG_TOL, 16'd0);
        add_random(600, 300);
        drain();

        // widest radii, no center may move
        write_radius(CFG_CUTOFF, 16'hFFFF);
        write_radius(CFG_EXCLUDE, 16'hFFFF);
        write_radius(CFG_DRIFT, 16'd0);
        write_radius(CFG_TOL, 16'hFFFF);
        add_random(500, 20000);
        drain();

        // middle settings with tight clusters
        write_radius(CFG_CUTOFF, 16'd1024);
        write_radius(CFG_EXCLUDE, 16'd3000);
        write_radius(CFG_DRIFT, 16'd2000);
        write_radius(CFG_TOL, 16'd4);
        add_random(700, 1200);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/lcau_pkg.sv
src/lcau_cell.sv
src/lcau_dist.sv
src/lcau_div.sv
src/leader_cluster_assign_update_unit.sv
bench/leader_cluster_assign_update_unit_test.sv
